// File: hw/rtl/csw_pkg.sv
// Shared constants, codes and types of the counting semaphore block.
`default_nettype none

package csw_pkg;

   localparam int NUM_SEMAPHORES = 16;
   localparam int NUM_PROCESSES  = 16;

   localparam int SemSlots  = (NUM_SEMAPHORES < 16) ? NUM_SEMAPHORES : 16;
   localparam int ProcSlots = (NUM_PROCESSES < 16) ? NUM_PROCESSES : 16;
   localparam int SemIdxW   = $clog2(SemSlots);
   localparam int ProcIdxW  = $clog2(ProcSlots);
   localparam int RelCap    = ProcSlots;
   localparam int RelCntW   = $clog2(RelCap + 1);

   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   localparam logic [1:0] FUNC_CREATE = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_WAIT   = 2'd2;
   localparam logic [1:0] FUNC_POST   = 2'd3;

   localparam logic signed [15:0] CountMax = 16'sh7fff;
   localparam logic signed [15:0] CountMin = 16'sh8000;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  sem_id;
      logic [3:0]  process_id;
      logic [14:0] initial_count;
      logic        sid_ok;
      logic        pid_ok;
   } cmd_type;

   typedef struct packed {
      logic       status;
      logic [3:0] handle;
      logic       blocked;
      logic       released_valid;
      logic [3:0] released_pid;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/csw_front.sv
// Front end: accept request beats, range-check handles and queue decoded commands.
`default_nettype none

module csw_front
   import csw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_func,
   input  wire logic [3:0] req_sem_id,
   input  wire logic [3:0] req_process_id,
   input  wire logic [14:0] req_initial_count,
   output logic            cmd_valid,
   output cmd_type         cmd,
   input  wire logic       cmd_pop
);

   cmd_type            q_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   cnt_ff, cnt_in;
   cmd_type            new_cmd;
   logic               push;

   always_comb begin
      new_cmd.func          = req_func;
      new_cmd.sem_id        = req_sem_id;
      new_cmd.process_id    = req_process_id;
      new_cmd.initial_count = req_initial_count;
      new_cmd.sid_ok        = ({1'b0, req_sem_id} < 5'(SemSlots));
      new_cmd.pid_ok        = ({1'b0, req_process_id} < 5'(ProcSlots));
   end

   assign req_ready = (cnt_ff < QCntW'(QueueDepth));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? QPtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !cmd_pop) begin
         cnt_in = QCntW'(cnt_ff + 1'b1);
      end else if (!push && cmd_pop) begin
         cnt_in = QCntW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/csw_back.sv
// Back end: semaphore table, wait-queue links, delete walker and result register.
`default_nettype none

module csw_back
   import csw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                   state_ff, state_in;
   logic [RelCntW-1:0]     rem_ff, rem_in;
   logic [3:0]             walk_pid_ff, walk_pid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [SemSlots-1:0]    slot_ff;
   logic signed [15:0]     count_ff [SemSlots];
   logic [3:0]             head_ff  [SemSlots];
   logic [3:0]             tail_ff  [SemSlots];
   logic [3:0]             link_ff  [ProcSlots];

   logic                   out_free;
   logic                   load;
   logic [SemIdxW-1:0]     sidx;
   logic signed [15:0]     c;
   logic [3:0]             hd;
   logic [3:0]             tl;
   logic                   in_use;
   logic                   free_found;
   logic [SemIdxW-1:0]     free_idx;
   logic [3:0]             link_addr;
   logic [3:0]             link_val;
   logic [15:0]            mag;
   logic [RelCntW-1:0]     n_rel;

   logic                   slot_set, slot_clr;
   logic [SemIdxW-1:0]     wr_idx;
   logic                   cnt_we;
   logic signed [15:0]     cnt_wd;
   logic                   head_we;
   logic [3:0]             head_wd;
   logic                   tail_we;
   logic [3:0]             tail_wd;
   logic                   link_we;
   logic [ProcIdxW-1:0]    link_wa;
   logic [3:0]             link_wd;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_pop   = cmd_valid && out_free && (state_ff == ST_IDLE);
   assign load      = cmd_pop || ((state_ff == ST_WALK) && out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign sidx   = cmd.sem_id[SemIdxW-1:0];
   assign c      = count_ff[sidx];
   assign hd     = head_ff[sidx];
   assign tl     = tail_ff[sidx];
   assign in_use = cmd.sid_ok && slot_ff[sidx];

   assign link_addr = (state_ff == ST_WALK) ? walk_pid_ff : hd;
   assign link_val  = ({1'b0, link_addr} < 5'(ProcSlots)) ?
                      link_ff[link_addr[ProcIdxW-1:0]] : 4'd0;

   assign mag   = 16'(-c);
   assign n_rel = !c[15] ? '0 :
                  (mag > 16'(RelCap)) ? RelCntW'(RelCap) : mag[RelCntW-1:0];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SemSlots - 1; i >= 0; i--) begin
         if (!slot_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SemIdxW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      walk_pid_in  = walk_pid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      slot_set     = 1'b0;
      slot_clr     = 1'b0;
      wr_idx       = sidx;
      cnt_we       = 1'b0;
      cnt_wd       = c;
      head_we      = 1'b0;
      head_wd      = 4'd0;
      tail_we      = 1'b0;
      tail_wd      = 4'd0;
      link_we      = 1'b0;
      link_wa      = tl[ProcIdxW-1:0];
      link_wd      = cmd.process_id;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff == ST_WALK) begin
         if (out_free) begin
            rsp_valid_in          = 1'b1;
            rsp_in                = '0;
            rsp_in.released_valid = 1'b1;
            rsp_in.released_pid   = walk_pid_ff;
            rsp_in.last           = (rem_ff == RelCntW'(1));
            walk_pid_in           = link_val;
            rem_in                = RelCntW'(rem_ff - 1'b1);
            if (rem_ff == RelCntW'(1)) begin
               state_in = ST_IDLE;
            end
         end
      end else if (cmd_pop) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.last  = 1'b1;
         case (cmd.func)
            FUNC_CREATE: begin
               if (free_found) begin
                  slot_set      = 1'b1;
                  wr_idx        = free_idx;
                  cnt_we        = 1'b1;
                  cnt_wd        = $signed({1'b0, cmd.initial_count});
                  head_we       = 1'b1;
                  tail_we       = 1'b1;
                  rsp_in.handle = 4'(free_idx);
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
            FUNC_DELETE: begin
               if (!in_use) begin
                  rsp_in.status = 1'b1;
               end else begin
                  slot_clr = 1'b1;
                  cnt_we   = 1'b1;
                  cnt_wd   = '0;
                  head_we  = 1'b1;
                  tail_we  = 1'b1;
                  if (n_rel != '0) begin
                     rsp_in.released_valid = 1'b1;
                     rsp_in.released_pid   = hd;
                     rsp_in.last           = (n_rel == RelCntW'(1));
                     if (n_rel != RelCntW'(1)) begin
                        state_in    = ST_WALK;
                        rem_in      = RelCntW'(n_rel - 1'b1);
                        walk_pid_in = link_val;
                     end
                  end
               end
            end
            FUNC_WAIT: begin
               if (!in_use || !cmd.pid_ok) begin
                  rsp_in.status = 1'b1;
               end else begin
                  cnt_we = (c != CountMin);
                  cnt_wd = c - 16'sd1;
                  if (c <= 16'sd0) begin
                     rsp_in.blocked = 1'b1;
                     tail_we        = 1'b1;
                     tail_wd        = cmd.process_id;
                     if (c == 16'sd0) begin
                        head_we = 1'b1;
                        head_wd = cmd.process_id;
                     end else begin
                        link_we = ({1'b0, tl} < 5'(ProcSlots));
                     end
                  end
               end
            end
            FUNC_POST: begin
               if (!in_use) begin
                  rsp_in.status = 1'b1;
               end else begin
                  cnt_we = (c != CountMax);
                  cnt_wd = c + 16'sd1;
                  if (c < 16'sd0) begin
                     rsp_in.released_valid = 1'b1;
                     rsp_in.released_pid   = hd;
                     if (c < -16'sd1) begin
                        head_we = 1'b1;
                        head_wd = link_val;
                     end
                  end
               end
            end
            default: begin
               rsp_in.status = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         if (slot_set) begin
            slot_ff[wr_idx] <= 1'b1;
         end else if (slot_clr) begin
            slot_ff[wr_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_pid_ff <= walk_pid_in;
      rsp_ff      <= rsp_in;
      if (cnt_we) begin
         count_ff[wr_idx] <= cnt_wd;
      end
      if (head_we) begin
         head_ff[wr_idx] <= head_wd;
      end
      if (tail_we) begin
         tail_ff[wr_idx] <= tail_wd;
      end
      if (link_we) begin
         link_ff[link_wa] <= link_wd;
      end
   end

`ifndef NO_ASSERTIONS
   a_walk_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> rem_ff != '0)
      else $error("delete walker active with nothing left to release");

   a_pop_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_valid_ff)
      else $error("command taken but no result loaded");

   a_walk_counts_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && out_free) |=> rem_ff == RelCntW'($past(rem_ff) - 1'b1))
      else $error("release count did not advance");

   a_create_marks_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.func == FUNC_CREATE && free_found) |=> slot_ff[$past(free_idx)])
      else $error("created slot not marked in use");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/counting_semaphore_wait_queues.sv
// Top level of the counting semaphore table with per-semaphore wait queues.
// Requests enter a two-beat command queue and are carried out by the back end one at a
// time: create, wait, post and a delete with no waiters each give one result beat, which
// the back end loads into its result register when it takes the command from the queue.
// A delete with n waiters gives one result beat per waiter, at most sixteen, one per cycle
// while the result register is free, walking the waiter links from the head.
// A full command queue stalls the request side; a result register held full stalls the back end.
`default_nettype none

module counting_semaphore_wait_queues
   import csw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // sem_id[3:0], process_id[7:4], initial_count[22:8]
   input  wire logic [1:0]  req_tuser,  // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // status[0], handle[4:1], blocked[5],
                                        // released_valid[6], released_pid[10:7]
   output logic             rsp_tlast
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   rsp_type rsp;

   csw_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_func          (req_tuser),
      .req_sem_id        (req_tdata[3:0]),
      .req_process_id    (req_tdata[7:4]),
      .req_initial_count (req_tdata[22:8]),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   csw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.released_pid, rsp.released_valid, rsp.blocked,
                       rsp.handle, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire

// File: test/semaphore_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the result beats of the semaphore table and compares them as they leave.
module semaphore_checker
   import csw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          pending
);

   logic               slot_busy [NUM_SEMAPHORES];
   logic signed [15:0] sem_level [NUM_SEMAPHORES];
   logic [3:0]         wait_head [NUM_SEMAPHORES];
   logic [3:0]         wait_tail [NUM_SEMAPHORES];
   logic [3:0]         wait_link [NUM_PROCESSES];
   rsp_type            outcome_q [$];
   int                 error_count = 0;

   assign mismatches = error_count;

   function automatic void report_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         if (error_count < 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void apply_request(logic [1:0] op, logic [3:0] sid, logic [3:0] pid,
                                         logic [14:0] init);
      rsp_type    beat;
      int         level;
      int         walk;
      logic [3:0] cursor;
      bit         placed;
      beat = '0;
      beat.last = 1'b1;
      placed = 1'b0;
      if (op == FUNC_CREATE) begin
         for (int i = 0; i < SemSlots; i++) begin
            if (!placed && !slot_busy[i]) begin
               placed = 1'b1;
               slot_busy[i] = 1'b1;
               sem_level[i] = 16'(init);
               wait_head[i] = '0;
               wait_tail[i] = '0;
               beat.handle = 4'(i);
            end
         end
         beat.status = !placed;
         outcome_q.push_back(beat);
      end else if (int'(sid) >= NUM_SEMAPHORES || !slot_busy[sid]) begin
         beat.status = 1'b1;
         outcome_q.push_back(beat);
      end else begin
         level = sem_level[sid];
         case (op)
            FUNC_DELETE: begin
               walk = (level < 0) ? -level : 0;
               if (walk > RelCap)
                  walk = RelCap;
               slot_busy[sid] = 1'b0;
               sem_level[sid] = '0;
               cursor = wait_head[sid];
               wait_head[sid] = '0;
               wait_tail[sid] = '0;
               if (walk == 0)
                  outcome_q.push_back(beat);
               for (int k = 0; k < walk; k++) begin
                  beat.released_valid = 1'b1;
                  beat.released_pid = cursor;
                  beat.last = (k == walk - 1);
                  outcome_q.push_back(beat);
                  if (k < walk - 1)
                     cursor = wait_link[cursor];
               end
            end
            FUNC_WAIT: begin
               if (int'(pid) >= NUM_PROCESSES) begin
                  beat.status = 1'b1;
               end else begin
                  if (level > int'(CountMin))
                     sem_level[sid] = 16'(level - 1);
                  if (level - 1 < 0) begin
                     if (level >= 0)
                        wait_head[sid] = pid;
                     else
                        wait_link[wait_tail[sid]] = pid;
                     wait_tail[sid] = pid;
                     beat.blocked = 1'b1;
                  end
               end
               outcome_q.push_back(beat);
            end
            FUNC_POST: begin
               if (level < int'(CountMax))
                  sem_level[sid] = 16'(level + 1);
               if (level < 0) begin
                  beat.released_valid = 1'b1;
                  beat.released_pid = wait_head[sid];
                  if (level < -1)
                     wait_head[sid] = wait_link[wait_head[sid]];
               end
               outcome_q.push_back(beat);
            end
            default: begin
            end
         endcase
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type seen;
      if (reset) begin
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            slot_busy[i] = 1'b0;
            sem_level[i] = '0;
            wait_head[i] = '0;
            wait_tail[i] = '0;
         end
         for (int i = 0; i < NUM_PROCESSES; i++)
            wait_link[i] = '0;
         outcome_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata[3:0], req_tdata[7:4], req_tdata[22:8]);
         if (rsp_tvalid && rsp_tready) begin
            seen.status = rsp_tdata[0];
            seen.handle = rsp_tdata[4:1];
            seen.blocked = rsp_tdata[5];
            seen.released_valid = rsp_tdata[6];
            seen.released_pid = rsp_tdata[10:7];
            seen.last = rsp_tlast;
            if (outcome_q.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: result beat with nothing expected", $time);
               error_count++;
            end else begin
               want = outcome_q.pop_front();
               report_field("status", want.status, seen.status);
               report_field("handle", want.handle, seen.handle);
               report_field("blocked", want.blocked, seen.blocked);
               report_field("released_valid", want.released_valid, seen.released_valid);
               report_field("released_pid", want.released_pid, seen.released_pid);
               report_field("last", want.last, seen.last);
            end
         end
      end
      pending <= outcome_q.size();
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Top of the semaphore table testbench: clock, reset, request and result traffic, verdict.
module tb_top;
   import csw_pkg::*;

   localparam int unsigned CycleLimit  = 2_000_000;
   localparam int          QueuedWaits = 20;
   localparam int          RandomItems = 230;
   localparam int          HoldCycles  = 120;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // sem_id[3:0], process_id[7:4], initial_count[22:8]
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // status[0], handle[4:1], blocked[5],
                                  // released_valid[6], released_pid[10:7]
   logic        rsp_tlast;
   int          mismatches;
   int          pending;
   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned cycle_count = 0;

   counting_semaphore_wait_queues dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   semaphore_checker table_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("counting_semaphore_wait_queues verification failed");
         $finish;
      end
   end

   task automatic push_request(input logic [1:0] op, input logic [3:0] sid,
                               input logic [3:0] pid, input logic [14:0] init);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, init, pid, sid};
      do @(posedge clock); while (!req_tready);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_until_settled();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : sink
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int          i;
      int          roll;
      logic [1:0]  op;
      logic [3:0]  sid;
      logic [3:0]  pid;
      logic [14:0] init;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // unused handle, then a sixteen-deep queue with a requeued process
      push_request(FUNC_WAIT, 4'd5, 4'd15, 15'd0);
      push_request(FUNC_CREATE, 4'd0, 4'd0, 15'd0);
      for (i = 0; i < 16; i++)
         push_request(FUNC_WAIT, 4'd0, 4'(i), 15'h7fff);
      push_request(FUNC_WAIT, 4'd0, 4'd0, 15'd0);
      push_request(FUNC_POST, 4'd0, 4'd9, 15'd0);
      push_request(FUNC_DELETE, 4'd0, 4'd0, 15'd0);
      // saturate at the top, then drop a semaphore with nobody waiting
      push_request(FUNC_CREATE, 4'd15, 4'd15, 15'h7fff);
      push_request(FUNC_POST, 4'd0, 4'd0, 15'd0);
      push_request(FUNC_WAIT, 4'd0, 4'd15, 15'd0);
      push_request(FUNC_DELETE, 4'd0, 4'd0, 15'd0);
      wait_until_settled();

      // fill the table, overflow it, and queue a long line on slot 0
      for (i = 0; i < 16; i++)
         push_request(FUNC_CREATE, 4'($urandom), 4'($urandom),
                      (i == 0) ? 15'd0 : 15'($urandom));
      push_request(FUNC_CREATE, 4'd0, 4'd0, 15'h7fff);
      for (i = 0; i < QueuedWaits; i++)
         push_request(FUNC_WAIT, 4'd0, 4'($urandom), 15'($urandom));
      push_request(FUNC_POST, 4'd0, 4'($urandom), 15'd0);
      for (i = 0; i < 16; i++)
         push_request(FUNC_DELETE, 4'(i), 4'($urandom), 15'($urandom));
      wait_until_settled();

      for (i = 0; i < RandomItems; i++) begin
         if (i == 100)
            hold_request = 1'b1;
         if (i == 150)
            wait_until_settled();
         if (i == 190)
            idle_on = 1'b0;
         roll = $urandom_range(0, 99);
         sid = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
         pid = 4'($urandom);
         init = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3));
         if (roll < 12)
            op = FUNC_CREATE;
         else if (roll < 20)
            op = FUNC_DELETE;
         else if (roll < 60)
            op = FUNC_WAIT;
         else
            op = FUNC_POST;
         push_request(op, sid, pid, init);
      end

      wait_until_settled();
      repeat (20) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("counting_semaphore_wait_queues verification clean");
      end else begin
         $display("counting_semaphore_wait_queues verification failed");
      end
      $finish;
   end

endmodule
